[rtl/core/drpp_pkg.sv]
package drpp_pkg;

  localparam logic [3:0] HDR_BYTES = 4'd12;
  localparam logic [3:0] RAD_BYTES = 4'd6;
  localparam int HDR_WORDS = 6;
  localparam int RAD_WORDS = 3;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_RADIAL = 4'b0010,
    PH_LEVELS = 4'b0100,
    PH_PAD    = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_RADIAL = 2'd1,
    KIND_LEVEL  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] first_bin;
    logic [15:0] bin_count;
    logic [15:0] x_origin;
    logic [15:0] y_origin;
    logic [15:0] scale;
    logic [15:0] radial_count;
    logic [15:0] radial_index;
    logic [15:0] level_count;
    logic [15:0] start_angle;
    logic [15:0] delta_angle;
    logic [7:0]  level_value;
  } result_t;

endpackage

[rtl/core/drpp_parser.sv]
module drpp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output drpp_pkg::result_t res_o
);
  import drpp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  byte_position_q, byte_position_d;
  logic [7:0]  high_byte_q, high_byte_d;
  logic [15:0] hw_q [HDR_WORDS];
  logic [15:0] hw_d [HDR_WORDS];
  logic [15:0] rw_q [RAD_WORDS];
  logic [15:0] rw_d [RAD_WORDS];
  logic [15:0] radials_done_q, radials_done_d;
  logic [15:0] levels_done_q, levels_done_d;

  logic [3:0]  limit;
  logic [3:0]  pos;
  logic [15:0] word;
  logic [15:0] rd_inc;
  logic [15:0] lvl_inc;
  phase_e      fin_phase;

  assign word      = {high_byte_q, byte_i};
  assign rd_inc    = radials_done_q + 16'd1;
  assign lvl_inc   = levels_done_q + 16'd1;
  // end of radial: next radial or back to a packet header
  assign fin_phase = (rd_inc == hw_q[5]) ? PH_HEADER : PH_RADIAL;
  assign limit     = (phase_q == PH_HEADER) ? HDR_BYTES : RAD_BYTES;
  assign pos       = (byte_position_q >= limit) ? 4'd0 : byte_position_q;

  always_comb begin
    phase_d         = phase_q;
    byte_position_d = byte_position_q;
    high_byte_d     = high_byte_q;
    hw_d            = hw_q;
    rw_d            = rw_q;
    radials_done_d  = radials_done_q;
    levels_done_d   = levels_done_q;
    res_valid_o     = 1'b0;
    res_o           = '0;
    if (step_i) begin
      case (phase_q)
        PH_HEADER, PH_RADIAL: begin
          if (!pos[0]) begin
            high_byte_d     = byte_i;
            byte_position_d = pos + 4'd1;
          end else begin
            if (phase_q == PH_HEADER) begin
              hw_d[pos[3:1]] = word;
            end else begin
              rw_d[pos[2:1]] = word;
            end
            if (pos + 4'd1 < limit) begin
              byte_position_d = pos + 4'd1;
            end else begin
              byte_position_d = 4'd0;
              res_valid_o     = 1'b1;
              levels_done_d   = 16'd0;
              if (phase_q == PH_HEADER) begin
                res_o.kind         = KIND_HEADER;
                res_o.first_bin    = hw_d[0];
                res_o.bin_count    = hw_d[1];
                res_o.x_origin     = hw_d[2];
                res_o.y_origin     = hw_d[3];
                res_o.scale        = hw_d[4];
                res_o.radial_count = hw_d[5];
                radials_done_d     = 16'd0;
                phase_d            = (hw_d[5] == 16'd0) ? PH_HEADER : PH_RADIAL;
              end else begin
                res_o.kind         = KIND_RADIAL;
                res_o.radial_index = radials_done_q;
                res_o.level_count  = rw_d[0];
                res_o.start_angle  = rw_d[1];
                res_o.delta_angle  = rw_d[2];
                if (rw_d[0] == 16'd0) begin
                  radials_done_d = rd_inc;
                  phase_d        = fin_phase;
                end else begin
                  phase_d = PH_LEVELS;
                end
              end
            end
          end
        end
        PH_LEVELS: begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_LEVEL;
          res_o.radial_index = radials_done_q;
          res_o.level_value  = byte_i;
          levels_done_d      = lvl_inc;
          if (lvl_inc >= rw_q[0]) begin
            if (rw_q[0][0]) begin
              phase_d = PH_PAD;
            end else begin
              radials_done_d  = rd_inc;
              byte_position_d = 4'd0;
              phase_d         = fin_phase;
            end
          end
        end
        PH_PAD: begin
          // pad byte after an odd level count, value ignored
          radials_done_d  = rd_inc;
          byte_position_d = 4'd0;
          phase_d         = fin_phase;
        end
        default: begin
          phase_d         = PH_HEADER;
          byte_position_d = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HEADER;
      byte_position_q <= 4'd0;
      high_byte_q     <= 8'd0;
      hw_q            <= '{default: '0};
      rw_q            <= '{default: '0};
      radials_done_q  <= 16'd0;
      levels_done_q   <= 16'd0;
    end else begin
      phase_q         <= phase_d;
      byte_position_q <= byte_position_d;
      high_byte_q     <= high_byte_d;
      hw_q            <= hw_d;
      rw_q            <= rw_d;
      radials_done_q  <= radials_done_d;
      levels_done_q   <= levels_done_d;
    end
  end

endmodule

[rtl/core/digital_radial_packet_parser_unit.sv]
// Digital radial data array packet parser.
// Input channel (in_valid_i / in_ready_o / data_byte_i): one packet byte per
// item, starting with the byte after the packet code.
// Output channel (out_valid_o / out_ready_i): one item per packet header,
// per radial header and per level byte; kind_o tells which, and fields that
// do not belong to that kind read as zero. Pad bytes and header bytes
// other than the last of a header give no item.
// Path: a byte accepted into the input register is parsed from there, and
// its item is loaded into the output register once the byte is consumed,
// which waits while the output register holds an item that is not taken.
// Throughput: one byte per cycle unless the output register stalls; the
// parse state update is a single short step between the two registers.
// Reset: the parser waits for a packet header, all words and counters are
// cleared, and both registers are empty.
// Stall: while an item waits in the output register, the byte in the input
// register is held; in_ready_o stays high while the input register is
// empty, so one more byte is taken before the input side stops.
module digital_radial_packet_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [15:0]        first_bin_o,
  output logic [15:0]        bin_count_o,
  output logic signed [15:0] x_origin_o,
  output logic signed [15:0] y_origin_o,
  output logic [15:0]        scale_o,
  output logic [15:0]        radial_count_o,
  output logic [15:0]        radial_index_o,
  output logic [15:0]        level_count_o,
  output logic [15:0]        start_angle_o,
  output logic [15:0]        delta_angle_o,
  output logic [7:0]         level_value_o
);
  import drpp_pkg::*;

  logic    in_valid_q;
  logic [7:0] in_data_q;
  logic    out_valid_q;
  result_t out_q;
  logic    consume;
  logic    res_valid;
  result_t res;

  assign consume    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | consume;

  drpp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (consume),
    .byte_i     (in_data_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready_i || !out_valid_q) begin
        out_valid_q <= consume & res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= data_byte_i;
    end
    if (consume && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign first_bin_o    = out_q.first_bin;
  assign bin_count_o    = out_q.bin_count;
  assign x_origin_o     = signed'(out_q.x_origin);
  assign y_origin_o     = signed'(out_q.y_origin);
  assign scale_o        = out_q.scale;
  assign radial_count_o = out_q.radial_count;
  assign radial_index_o = out_q.radial_index;
  assign level_count_o  = out_q.level_count;
  assign start_angle_o  = out_q.start_angle;
  assign delta_angle_o  = out_q.delta_angle;
  assign level_value_o  = out_q.level_value;

endmodule

[bench/drpp_parse_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the packet parser, keeps a shadow parse state,
// and compares each output item against the oldest predicted one.
module drpp_parse_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         data_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         kind_i,
  input  logic [15:0]        first_bin_i,
  input  logic [15:0]        bin_count_i,
  input  logic signed [15:0] x_origin_i,
  input  logic signed [15:0] y_origin_i,
  input  logic [15:0]        scale_i,
  input  logic [15:0]        radial_count_i,
  input  logic [15:0]        radial_index_i,
  input  logic [15:0]        level_count_i,
  input  logic [15:0]        start_angle_i,
  input  logic [15:0]        delta_angle_i,
  input  logic [7:0]         level_value_i,
  output int                 mismatches_o,
  output int                 pending_o
);
  import drpp_pkg::*;

  // shadow parse state
  phase_e      ph;
  logic [3:0]  bpos;
  logic [7:0]  hi_byte;
  logic [15:0] hdr_w [HDR_WORDS];
  logic [15:0] rad_w [RAD_WORDS];
  logic [15:0] rad_done;
  logic [15:0] lvl_done;

  result_t     parsed_q [$];
  result_t     want;
  int          errs;

  function automatic void close_radial();
    rad_done = rad_done + 16'd1;
    bpos     = 4'd0;
    ph       = (rad_done == hdr_w[5]) ? PH_HEADER : PH_RADIAL;
  endfunction

  // advance the shadow parser by one byte, queueing the item it produces
  task automatic parse_byte(input logic [7:0] b);
    logic [3:0]  lim;
    logic [3:0]  pos;
    logic [15:0] w;
    result_t     r;
    r = '0;
    case (ph)
      PH_HEADER, PH_RADIAL: begin
        lim = (ph == PH_HEADER) ? HDR_BYTES : RAD_BYTES;
        pos = (bpos >= lim) ? 4'd0 : bpos;
        if (!pos[0]) begin
          hi_byte = b;
          bpos    = pos + 4'd1;
        end else begin
          w = {hi_byte, b};
          if (ph == PH_HEADER) hdr_w[pos[3:1]] = w;
          else rad_w[pos[2:1]] = w;
          if (pos + 4'd1 < lim) begin
            bpos = pos + 4'd1;
          end else begin
            bpos = 4'd0;
            if (ph == PH_HEADER) begin
              r.kind         = KIND_HEADER;
              r.first_bin    = hdr_w[0];
              r.bin_count    = hdr_w[1];
              r.x_origin     = hdr_w[2];
              r.y_origin     = hdr_w[3];
              r.scale        = hdr_w[4];
              r.radial_count = hdr_w[5];
              rad_done       = 16'd0;
              lvl_done       = 16'd0;
              ph             = (hdr_w[5] == 16'd0) ? PH_HEADER : PH_RADIAL;
            end else begin
              r.kind         = KIND_RADIAL;
              r.radial_index = rad_done;
              r.level_count  = rad_w[0];
              r.start_angle  = rad_w[1];
              r.delta_angle  = rad_w[2];
              lvl_done       = 16'd0;
              if (rad_w[0] == 16'd0) close_radial();
              else ph = PH_LEVELS;
            end
            parsed_q.push_back(r);
          end
        end
      end
      PH_LEVELS: begin
        r.kind         = KIND_LEVEL;
        r.radial_index = rad_done;
        r.level_value  = b;
        parsed_q.push_back(r);
        lvl_done = lvl_done + 16'd1;
        if (lvl_done >= rad_w[0]) begin
          if (rad_w[0][0]) ph = PH_PAD;
          else close_radial();
        end
      end
      // pad byte: value ignored
      default: close_radial();
    endcase
  endtask

  task automatic check_field(input string label, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, label, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph       = PH_HEADER;
      bpos     = 4'd0;
      hi_byte  = 8'd0;
      rad_done = 16'd0;
      lvl_done = 16'd0;
      for (int i = 0; i < HDR_WORDS; i++) hdr_w[i] = 16'd0;
      for (int i = 0; i < RAD_WORDS; i++) rad_w[i] = 16'd0;
      parsed_q.delete();
      errs = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (parsed_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual kind %0d", $time, kind_i);
          errs++;
        end else begin
          want = parsed_q.pop_front();
          check_field("kind",         16'(want.kind),        16'(kind_i));
          check_field("first_bin",    want.first_bin,        first_bin_i);
          check_field("bin_count",    want.bin_count,        bin_count_i);
          check_field("x_origin",     want.x_origin,         x_origin_i);
          check_field("y_origin",     want.y_origin,         y_origin_i);
          check_field("scale",        want.scale,            scale_i);
          check_field("radial_count", want.radial_count,     radial_count_i);
          check_field("radial_index", want.radial_index,     radial_index_i);
          check_field("level_count",  want.level_count,      level_count_i);
          check_field("start_angle",  want.start_angle,      start_angle_i);
          check_field("delta_angle",  want.delta_angle,      delta_angle_i);
          check_field("level_value",  16'(want.level_value), 16'(level_value_i));
        end
      end
      if (in_valid_i && in_ready_i) parse_byte(data_byte_i);
      mismatches_o <= errs;
      pending_o    <= parsed_q.size();
    end
  end

endmodule

[bench/digital_radial_packet_parser_unit_tb.sv]
`timescale 1ns / 100ps

module digital_radial_packet_parser_unit_tb;
  import drpp_pkg::*;

  localparam int MAX_CYCLES = 200000;
  localparam int RAND_BYTES = 750;
  localparam int HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic out_ready = 1'b0;

  logic               in_ready;
  logic               out_valid;
  logic [1:0]         kind;
  logic [15:0]        first_bin;
  logic [15:0]        bin_count;
  logic signed [15:0] x_origin;
  logic signed [15:0] y_origin;
  logic [15:0]        scale;
  logic [15:0]        radial_count;
  logic [15:0]        radial_index;
  logic [15:0]        level_count;
  logic [15:0]        start_angle;
  logic [15:0]        delta_angle;
  logic [7:0]         level_value;

  int mismatches;
  int pending;
  int cycles = 0;
  int stim_phase = 0;

  // per traffic phase: percent of cycles the sender idles / receiver stalls
  int send_idle_pct  [5] = '{0, 0, 74, 0, 31};
  int recv_stall_pct [5] = '{0, 0, 0, 74, 31};

  logic [7:0] stream_q [$];

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  digital_radial_packet_parser_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .first_bin_o    (first_bin),
    .bin_count_o    (bin_count),
    .x_origin_o     (x_origin),
    .y_origin_o     (y_origin),
    .scale_o        (scale),
    .radial_count_o (radial_count),
    .radial_index_o (radial_index),
    .level_count_o  (level_count),
    .start_angle_o  (start_angle),
    .delta_angle_o  (delta_angle),
    .level_value_o  (level_value)
  );

  drpp_parse_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .data_byte_i    (data_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .kind_i         (kind),
    .first_bin_i    (first_bin),
    .bin_count_i    (bin_count),
    .x_origin_i     (x_origin),
    .y_origin_i     (y_origin),
    .scale_i        (scale),
    .radial_count_i (radial_count),
    .radial_index_i (radial_index),
    .level_count_i  (level_count),
    .start_angle_i  (start_angle),
    .delta_angle_i  (delta_angle),
    .level_value_i  (level_value),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  task automatic push_word(input logic [15:0] w);
    stream_q.push_back(w[15:8]);
    stream_q.push_back(w[7:0]);
  endtask

  // well-formed packet with random content, small radial and level counts
  task automatic add_packet();
    int nrad;
    int nlev;
    nrad = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
    repeat (5) push_word(16'($urandom_range(0, 65535)));
    push_word(16'(nrad));
    repeat (nrad) begin
      nlev = $urandom_range(0, 9);
      push_word(16'(nlev));
      push_word(16'($urandom_range(0, 65535)));
      push_word(16'($urandom_range(0, 65535)));
      repeat (nlev) stream_q.push_back(8'($urandom_range(0, 255)));
      if (nlev % 2) stream_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // header cut short and filled with zeros: radial count reads as zero
  task automatic add_cut_header();
    int k;
    k = $urandom_range(1, 10);
    repeat (k) stream_q.push_back(8'($urandom_range(0, 255)));
    repeat (12 - k) stream_q.push_back(8'h00);
  endtask

  initial begin
    int n_dir;
    int total;
    int p;
    // header with extreme words and two radials: one empty, one odd with pad
    push_word(16'hFFFF);
    push_word(16'h0000);
    push_word(16'h8000);
    push_word(16'h7FFF);
    push_word(16'h00FF);
    push_word(16'h0002);
    push_word(16'h0000);
    push_word(16'hFFFF);
    push_word(16'h0000);
    push_word(16'h0001);
    push_word(16'h0000);
    push_word(16'hFFFF);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    n_dir = stream_q.size();
    while (stream_q.size() < n_dir + RAND_BYTES) begin
      if ($urandom_range(0, 9) == 0) add_cut_header();
      else add_packet();
    end
    total = stream_q.size();

    wait (rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < total; i++) begin
      p = (i < n_dir) ? 0 : 1 + ((i - n_dir) * 4) / (total - n_dir);
      stim_phase <= p;
      while ($urandom_range(0, 99) < send_idle_pct[p]) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
      in_valid  <= 1'b1;
      data_byte <= stream_q[i];
      do @(posedge clk_i); while (!in_ready);
    end
    in_valid <= 1'b0;

    // let the pending count catch up with the last accepted byte
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // trailing pad byte may still be in flight without an item
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("digital_radial_packet_parser_unit verification clean");
    end else begin
      $display("digital_radial_packet_parser_unit verification failed");
    end
    $finish;
  end

  // receiver: random stalls per phase, one long hold-off to back up the input
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && stim_phase == 1) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct[stim_phase]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("digital_radial_packet_parser_unit verification failed");
      $finish;
    end
  end

endmodule
